/* design/tpbl_pkg.sv */
// ----------------------------------------------------------------------------
// tpbl_pkg
// Shared types, codes and helper functions for the two-party bakery lock.
// ----------------------------------------------------------------------------
package tpbl_pkg;

    localparam int TICKET_BITS = 16;
    localparam int FIELD_TICKET_BITS = 16;
    localparam int CORE_ID_BITS = 6;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    typedef logic [TICKET_BITS-1:0] ticket_t;
    typedef logic [FIELD_TICKET_BITS-1:0] field_ticket_t;
    typedef logic [CORE_ID_BITS-1:0] core_id_t;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_ACQUIRE = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    localparam logic SLOT_ENTERING = 1'b0;
    localparam logic SLOT_TICKET   = 1'b1;

    localparam logic REG_LOCAL_ID  = 1'b0;
    localparam logic REG_REMOTE_ID = 1'b1;

    localparam core_id_t LOCAL_ID_RESET  = core_id_t'(0);
    localparam core_id_t REMOTE_ID_RESET = core_id_t'(1);

    localparam logic [2:0] PHASE_IDLE         = 3'd0;
    localparam logic [2:0] PHASE_WAIT_FLAG    = 3'd1;
    localparam logic [2:0] PHASE_WAIT_TICKET  = 3'd2;
    localparam logic [2:0] PHASE_WAIT_PARTNER = 3'd3;
    localparam logic [2:0] PHASE_WAIT_TURN    = 3'd4;
    localparam logic [2:0] PHASE_HELD         = 3'd5;
    localparam logic [2:0] PHASE_RELEASING    = 3'd6;

    typedef enum logic [6:0] {
        ST_IDLE         = 7'b0000001,
        ST_WAIT_FLAG    = 7'b0000010,
        ST_WAIT_TICKET  = 7'b0000100,
        ST_WAIT_PARTNER = 7'b0001000,
        ST_WAIT_TURN    = 7'b0010000,
        ST_HELD         = 7'b0100000,
        ST_RELEASING    = 7'b1000000
    } lock_state_t;

    function automatic logic [2:0] phase_code(input lock_state_t st);
        logic [2:0] code;
        code = PHASE_IDLE;
        unique case (st)
            ST_IDLE:         code = PHASE_IDLE;
            ST_WAIT_FLAG:    code = PHASE_WAIT_FLAG;
            ST_WAIT_TICKET:  code = PHASE_WAIT_TICKET;
            ST_WAIT_PARTNER: code = PHASE_WAIT_PARTNER;
            ST_WAIT_TURN:    code = PHASE_WAIT_TURN;
            ST_HELD:         code = PHASE_HELD;
            ST_RELEASING:    code = PHASE_RELEASING;
            default:         code = PHASE_IDLE;
        endcase
        return code;
    endfunction

    function automatic ticket_t next_ticket(input ticket_t partner);
        ticket_t result;
        if (partner == '1)
        begin
            result = '1;
        end
        else
        begin
            result = partner + ticket_t'(1);
        end
        return result;
    endfunction

endpackage

/* design/two_party_bakery_lock.sv */
// ----------------------------------------------------------------------------
// two_party_bakery_lock
// One core's side of a two-party bakery lock with flags sent over a network.
// ----------------------------------------------------------------------------
// Each input transaction is an event (tick, acquire or release) together with
// the link-done flag and the entering flag and ticket the partner last wrote.
// Each input transaction yields exactly one output transaction carrying the
// send request (slot and value), the new phase, lock ownership and a flag for
// requests that did not fit the phase.
// Both channels use valid/ready. An accepted transaction is captured in an
// input register; its result is computed from there and registered in the
// output register once that register is free. One transaction is taken
// every cycle while the receiver does not stall. The rate is set by the
// single pass through the phase logic, one ticket increment and one ticket
// compare.
// When the receiver stalls, the output register holds its result and the
// input register holds the next transaction; in_ready drops only when both
// are full. The user is to write the two id registers over the APB port
// only while idle; the block does not enforce it. Reset clears both pipeline
// valid bits, idles the lock with ticket zero and loads ids local 0, remote 1.
// ----------------------------------------------------------------------------
module two_party_bakery_lock (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [tpbl_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tpbl_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tpbl_pkg::APB_DATA_BITS-1:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        link_done,
    input  logic        partner_entering,
    input  tpbl_pkg::field_ticket_t partner_ticket,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        send_valid,
    output logic        send_slot,
    output tpbl_pkg::field_ticket_t send_value,
    output logic        lock_held,
    output logic [2:0]  phase,
    output logic        request_ignored
);

    tpbl_pkg::core_id_t local_id_reg;
    tpbl_pkg::core_id_t remote_id_reg;

    logic                    in_valid_reg;
    tpbl_pkg::action_t       action_reg;
    logic                    link_done_reg;
    logic                    partner_entering_reg;
    tpbl_pkg::field_ticket_t partner_ticket_reg;

    tpbl_pkg::lock_state_t state_reg;
    tpbl_pkg::lock_state_t state_next;
    tpbl_pkg::ticket_t     ticket_reg;
    tpbl_pkg::ticket_t     ticket_next;

    logic                    out_valid_reg;
    logic                    send_valid_reg;
    logic                    send_slot_reg;
    tpbl_pkg::field_ticket_t send_value_reg;
    logic                    lock_held_reg;
    logic [2:0]              phase_reg;
    logic                    request_ignored_reg;

    logic                  send_valid_next;
    logic                  send_slot_next;
    tpbl_pkg::ticket_t     send_value_next;
    logic                  request_ignored_next;

    logic                  advance;
    logic                  fire;
    logic                  cfg_write;
    logic                  is_request;
    logic                  must_wait;
    tpbl_pkg::ticket_t     partner_tk;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tpbl_pkg::REG_REMOTE_ID)
        begin
            prdata[tpbl_pkg::CORE_ID_BITS-1:0] = remote_id_reg;
        end
        else
        begin
            prdata[tpbl_pkg::CORE_ID_BITS-1:0] = local_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg  <= tpbl_pkg::LOCAL_ID_RESET;
            remote_id_reg <= tpbl_pkg::REMOTE_ID_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == tpbl_pkg::REG_REMOTE_ID)
            begin
                remote_id_reg <= pwdata[tpbl_pkg::CORE_ID_BITS-1:0];
            end
            else
            begin
                local_id_reg <= pwdata[tpbl_pkg::CORE_ID_BITS-1:0];
            end
        end
    end

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg           <= tpbl_pkg::action_t'(action);
            link_done_reg        <= link_done;
            partner_entering_reg <= partner_entering;
            partner_ticket_reg   <= partner_ticket;
        end
    end

    assign partner_tk = tpbl_pkg::ticket_t'(partner_ticket_reg);
    assign is_request = (action_reg == tpbl_pkg::ACT_ACQUIRE) ||
                        (action_reg == tpbl_pkg::ACT_RELEASE);
    assign must_wait  = (partner_tk != '0) &&
                        ((partner_tk < ticket_reg) ||
                         ((partner_tk == ticket_reg) && (remote_id_reg < local_id_reg)));

    always_comb
    begin
        state_next           = state_reg;
        ticket_next          = ticket_reg;
        send_valid_next      = 1'b0;
        send_slot_next       = tpbl_pkg::SLOT_ENTERING;
        send_value_next      = '0;
        request_ignored_next = 1'b0;
        unique case (state_reg)
            tpbl_pkg::ST_IDLE:
            begin
                if (action_reg == tpbl_pkg::ACT_ACQUIRE)
                begin
                    send_valid_next = 1'b1;
                    send_slot_next  = tpbl_pkg::SLOT_ENTERING;
                    send_value_next = tpbl_pkg::ticket_t'(1);
                    state_next      = tpbl_pkg::ST_WAIT_FLAG;
                end
                else if (action_reg == tpbl_pkg::ACT_RELEASE)
                begin
                    request_ignored_next = 1'b1;
                end
            end
            tpbl_pkg::ST_WAIT_FLAG:
            begin
                request_ignored_next = is_request;
                if (link_done_reg)
                begin
                    ticket_next     = tpbl_pkg::next_ticket(partner_tk);
                    send_valid_next = 1'b1;
                    send_slot_next  = tpbl_pkg::SLOT_TICKET;
                    send_value_next = tpbl_pkg::next_ticket(partner_tk);
                    state_next      = tpbl_pkg::ST_WAIT_TICKET;
                end
            end
            tpbl_pkg::ST_WAIT_TICKET:
            begin
                request_ignored_next = is_request;
                if (link_done_reg)
                begin
                    send_valid_next = 1'b1;
                    send_slot_next  = tpbl_pkg::SLOT_ENTERING;
                    send_value_next = '0;
                    state_next      = tpbl_pkg::ST_WAIT_PARTNER;
                end
            end
            tpbl_pkg::ST_WAIT_PARTNER:
            begin
                request_ignored_next = is_request;
                if (!partner_entering_reg)
                begin
                    state_next = tpbl_pkg::ST_WAIT_TURN;
                end
            end
            tpbl_pkg::ST_WAIT_TURN:
            begin
                request_ignored_next = is_request;
                if (!must_wait)
                begin
                    state_next = tpbl_pkg::ST_HELD;
                end
            end
            tpbl_pkg::ST_HELD:
            begin
                if (action_reg == tpbl_pkg::ACT_RELEASE)
                begin
                    ticket_next     = '0;
                    send_valid_next = 1'b1;
                    send_slot_next  = tpbl_pkg::SLOT_TICKET;
                    send_value_next = '0;
                    state_next      = tpbl_pkg::ST_RELEASING;
                end
                else if (action_reg == tpbl_pkg::ACT_ACQUIRE)
                begin
                    request_ignored_next = 1'b1;
                end
            end
            tpbl_pkg::ST_RELEASING:
            begin
                request_ignored_next = is_request;
                if (link_done_reg)
                begin
                    state_next = tpbl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpbl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tpbl_pkg::ST_IDLE;
            ticket_reg <= '0;
        end
        else if (fire)
        begin
            state_reg  <= state_next;
            ticket_reg <= ticket_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            send_valid_reg      <= send_valid_next;
            send_slot_reg       <= send_slot_next;
            send_value_reg      <= tpbl_pkg::field_ticket_t'(send_value_next);
            lock_held_reg       <= (state_next == tpbl_pkg::ST_HELD);
            phase_reg           <= tpbl_pkg::phase_code(state_next);
            request_ignored_reg <= request_ignored_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign send_valid      = send_valid_reg;
    assign send_slot       = send_slot_reg;
    assign send_value      = send_value_reg;
    assign lock_held       = lock_held_reg;
    assign phase           = phase_reg;
    assign request_ignored = request_ignored_reg;

endmodule

/* tb/two_party_bakery_lock_tb.sv */
// ----------------------------------------------------------------------------
// two_party_bakery_lock_tb
// Self-checking testbench for one core's side of the two-party bakery lock.
// ----------------------------------------------------------------------------
// A short directed sequence walks two acquire and release rounds through every phase.
// It covers out-of-phase requests, the unused action code, ticket saturation
// and the wait for a lower partner ticket. Random transactions follow. Most of
// them are well-formed acquire and release sequences with random link and
// partner observations, mixed with noise. They run under several id settings:
// swapped ids, equal ids and the extremes. A scoreboard class predicts each
// result from the accepted events and checks every output transaction field
// by field. Both handshakes idle at random, and the receiver stalls once for
// a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module two_party_bakery_lock_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpbl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int EVENTS_PER_SETTING = 100;
    localparam int LONG_HOLD_CYCLES = 120;

    typedef struct {
        logic        send_valid;
        logic        send_slot;
        logic [15:0] send_value;
        logic        lock_held;
        logic [2:0]  phase;
        logic        request_ignored;
    } lock_result_t;

    class bakery_scoreboard;
        logic [2:0]     lock_phase_q;
        ticket_t        ticket;
        logic           entering;
        core_id_t       local_id;
        core_id_t       remote_id;
        lock_result_t   pending[$];
        int             mismatches;
        int             checked;
        int             grants;

        function new();
            lock_phase_q = PHASE_IDLE;
            ticket = '0;
            entering = 1'b0;
            local_id = LOCAL_ID_RESET;
            remote_id = REMOTE_ID_RESET;
            mismatches = 0;
            checked = 0;
            grants = 0;
        endfunction

        function void set_id(logic sel, core_id_t value);
            if (sel == REG_LOCAL_ID)
            begin
                local_id = value;
            end
            else
            begin
                remote_id = value;
            end
        endfunction

        function void note_event(action_t act, logic done, logic p_enter, ticket_t p_ticket);
            lock_result_t r;
            logic         req;
            logic         blocked;
            r = '{default: '0};
            req = (act == ACT_ACQUIRE) || (act == ACT_RELEASE);
            case (lock_phase_q)
                PHASE_IDLE:
                begin
                    if (act == ACT_ACQUIRE)
                    begin
                        entering = 1'b1;
                        r.send_valid = 1'b1;
                        r.send_slot = SLOT_ENTERING;
                        r.send_value = 16'd1;
                        lock_phase_q = PHASE_WAIT_FLAG;
                    end
                    else if (act == ACT_RELEASE)
                    begin
                        r.request_ignored = 1'b1;
                    end
                end
                PHASE_WAIT_FLAG:
                begin
                    r.request_ignored = req;
                    if (done)
                    begin
                        ticket = (p_ticket == '1) ? '1 : p_ticket + 1'b1;
                        r.send_valid = 1'b1;
                        r.send_slot = SLOT_TICKET;
                        r.send_value = ticket;
                        lock_phase_q = PHASE_WAIT_TICKET;
                    end
                end
                PHASE_WAIT_TICKET:
                begin
                    r.request_ignored = req;
                    if (done)
                    begin
                        entering = 1'b0;
                        r.send_valid = 1'b1;
                        r.send_slot = SLOT_ENTERING;
                        r.send_value = 16'd0;
                        lock_phase_q = PHASE_WAIT_PARTNER;
                    end
                end
                PHASE_WAIT_PARTNER:
                begin
                    r.request_ignored = req;
                    if (!p_enter)
                    begin
                        lock_phase_q = PHASE_WAIT_TURN;
                    end
                end
                PHASE_WAIT_TURN:
                begin
                    r.request_ignored = req;
                    blocked = (p_ticket != '0) && ((p_ticket < ticket) ||
                              ((p_ticket == ticket) && (remote_id < local_id)));
                    if (!blocked)
                    begin
                        lock_phase_q = PHASE_HELD;
                        grants++;
                    end
                end
                PHASE_HELD:
                begin
                    if (act == ACT_RELEASE)
                    begin
                        ticket = '0;
                        r.send_valid = 1'b1;
                        r.send_slot = SLOT_TICKET;
                        r.send_value = 16'd0;
                        lock_phase_q = PHASE_RELEASING;
                    end
                    else if (act == ACT_ACQUIRE)
                    begin
                        r.request_ignored = 1'b1;
                    end
                end
                PHASE_RELEASING:
                begin
                    r.request_ignored = req;
                    if (done)
                    begin
                        lock_phase_q = PHASE_IDLE;
                    end
                end
                default:
                begin
                    lock_phase_q = PHASE_IDLE;
                end
            endcase
            r.phase = lock_phase_q;
            r.lock_held = (lock_phase_q == PHASE_HELD);
            pending.push_back(r);
        endfunction

        function void check_result(lock_result_t got);
            lock_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: unexpected output transaction, phase %0d", got.phase);
                end
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.send_valid !== want.send_valid || got.send_slot !== want.send_slot ||
                got.send_value !== want.send_value || got.lock_held !== want.lock_held ||
                got.phase !== want.phase || got.request_ignored !== want.request_ignored)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: result %0d: expected send %b/%b/%h held %b phase %0d ign %b",
                             checked, want.send_valid, want.send_slot, want.send_value,
                             want.lock_held, want.phase, want.request_ignored);
                    $display("       got      send %b/%b/%h held %b phase %0d ign %b",
                             got.send_valid, got.send_slot, got.send_value,
                             got.lock_held, got.phase, got.request_ignored);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic        link_done;
    logic        partner_entering;
    logic [15:0] partner_ticket;
    logic        out_valid;
    logic        out_ready;
    logic        send_valid;
    logic        send_slot;
    logic [15:0] send_value;
    logic        lock_held;
    logic [2:0]  phase;
    logic        request_ignored;

    bakery_scoreboard sb = new();
    int  cycles = 0;
    int  events_sent = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    two_party_bakery_lock u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .link_done(link_done),
        .partner_entering(partner_entering),
        .partner_ticket(partner_ticket),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .send_valid(send_valid),
        .send_slot(send_slot),
        .send_value(send_value),
        .lock_held(lock_held),
        .phase(phase),
        .request_ignored(request_ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result('{send_valid, send_slot, send_value, lock_held, phase,
                              request_ignored});
        end
    end

    initial
    begin : receiver
        int unsigned hold;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                rx_burst = !rx_burst;
            end
            hold = rx_burst ? 0 : $urandom_range(0, 18);
            if (!long_hold_done && sb.checked >= 200)
            begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD_CYCLES;
            end
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_id(input logic sel, input core_id_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'(4 * int'(sel));
        pwdata <= APB_DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_id(sel, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic offer_event(input action_t act, input logic done, input logic p_enter,
                               input ticket_t p_ticket, input bit last);
        int unsigned gap;
        in_valid <= 1'b1;
        action <= act;
        link_done <= done;
        partner_entering <= p_enter;
        partner_ticket <= p_ticket;
        do @(posedge clk); while (!in_ready);
        sb.note_event(act, done, p_enter, p_ticket);
        events_sent++;
        if ($urandom_range(0, 29) == 0)
        begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap != 0 || last)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pick_event(output action_t act, output logic done, output logic p_enter,
                              output ticket_t p_ticket);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            act = action_t'($urandom_range(0, 3));
        end
        else if (sb.lock_phase_q == PHASE_IDLE)
        begin
            act = (roll < 70) ? ACT_ACQUIRE : ((roll < 85) ? ACT_TICK : ACT_RELEASE);
        end
        else if (sb.lock_phase_q == PHASE_HELD)
        begin
            act = (roll < 50) ? ACT_RELEASE : ((roll < 90) ? ACT_TICK : ACT_ACQUIRE);
        end
        else
        begin
            act = (roll < 85) ? ACT_TICK : ((roll < 93) ? ACT_ACQUIRE : ACT_RELEASE);
        end
        done = ($urandom_range(0, 9) < 6);
        p_enter = ($urandom_range(0, 9) < 4);
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            p_ticket = '0;
        end
        else if (roll < 45)
        begin
            p_ticket = sb.ticket;
        end
        else if (roll < 55)
        begin
            p_ticket = sb.ticket + 1'b1;
        end
        else if (roll < 65)
        begin
            p_ticket = sb.ticket - 1'b1;
        end
        else if (roll < 75)
        begin
            p_ticket = '1 - ticket_t'($urandom_range(0, 1));
        end
        else
        begin
            p_ticket = ticket_t'($urandom_range(0, 65535));
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        core_id_t id_pairs[5][2];
        action_t  act;
        logic     done;
        logic     p_enter;
        ticket_t  p_ticket;
        id_pairs = '{'{6'd0, 6'd63}, '{6'd63, 6'd0}, '{6'd63, 6'd63},
                     '{6'd0, 6'd0}, '{6'd21, 6'd42}};
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        action <= ACT_TICK;
        link_done <= 1'b0;
        partner_entering <= 1'b0;
        partner_ticket <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_event(ACT_TICK,    1'b1, 1'b1, 16'hFFFF, 1'b0);
        offer_event(ACT_RELEASE, 1'b0, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_UNUSED,  1'b1, 1'b1, 16'h5A5A, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b0, 1'b1, 16'h0003, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b0, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b1, 16'hFFFF, 1'b0);
        offer_event(ACT_RELEASE, 1'b1, 1'b1, 16'h1234, 1'b0);
        offer_event(ACT_TICK,    1'b0, 1'b1, 16'h0000, 1'b0);
        offer_event(ACT_UNUSED,  1'b0, 1'b0, 16'h8000, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b0, 16'hFFFE, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b0, 1'b0, 16'hFFFF, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b0, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b1, 16'h0000, 1'b0);
        offer_event(ACT_RELEASE, 1'b0, 1'b0, 16'hFFFF, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b0, 1'b1, 16'h0001, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_ACQUIRE, 1'b1, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_TICK,    1'b1, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_TICK,    1'b0, 1'b0, 16'h0001, 1'b0);
        offer_event(ACT_TICK,    1'b0, 1'b0, 16'h0000, 1'b0);
        offer_event(ACT_RELEASE, 1'b1, 1'b0, 16'h0000, 1'b1);
        drain();

        foreach (id_pairs[k])
        begin
            write_id(REG_LOCAL_ID, id_pairs[k][0]);
            write_id(REG_REMOTE_ID, id_pairs[k][1]);
            for (int i = 0; i < EVENTS_PER_SETTING; i++)
            begin
                pick_event(act, done, p_enter, p_ticket);
                offer_event(act, done, p_enter, p_ticket, i == EVENTS_PER_SETTING - 1);
            end
            drain();
        end
        repeat (10) @(posedge clk);

        $display("Sent %0d events under %0d id settings; checked %0d results, %0d lock grants.",
                 events_sent, $size(id_pairs) + 1, sb.checked, sb.grants);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* two_party_bakery_lock.f */
design/tpbl_pkg.sv
design/two_party_bakery_lock.sv
tb/two_party_bakery_lock_tb.sv
